// ===== design/pn2d_pkg.sv =====
package pn2d_pkg;

    localparam int FRAC_BITS_DEF = 8;
    localparam int TABLE_DEPTH   = 256;

    typedef logic        opcode_t;
    typedef logic [7:0]  perm_t;
    typedef logic signed [23:0] coord_t;
    typedef logic signed [15:0] noise_t;
    typedef logic [15:0] weight_t;

    localparam opcode_t OP_LOAD   = 1'b0;
    localparam opcode_t OP_SAMPLE = 1'b1;

    // corner gradient select, low two hash bits
    localparam logic [1:0] GRAD_PP = 2'd0;
    localparam logic [1:0] GRAD_NP = 2'd1;
    localparam logic [1:0] GRAD_NN = 2'd2;
    localparam logic [1:0] GRAD_PN = 2'd3;

endpackage

// ===== design/pn2d_in_if.sv =====
interface pn2d_in_if;
    import pn2d_pkg::*;

    logic    valid;
    logic    ready;
    opcode_t opcode;
    perm_t   table_index;
    perm_t   table_value;
    coord_t  x_coord;
    coord_t  y_coord;

    modport source (
        output valid,
        input  ready,
        output opcode,
        output table_index,
        output table_value,
        output x_coord,
        output y_coord
    );

    modport sink (
        input  valid,
        output ready,
        input  opcode,
        input  table_index,
        input  table_value,
        input  x_coord,
        input  y_coord
    );
endinterface

// ===== design/pn2d_out_if.sv =====
interface pn2d_out_if;
    import pn2d_pkg::*;

    logic   valid;
    logic   ready;
    noise_t noise_value;

    modport source (
        output valid,
        input  ready,
        output noise_value
    );

    modport sink (
        input  valid,
        output ready,
        input  noise_value
    );
endinterface

// ===== design/perlin_noise_2d_top.sv =====
// 2D gradient noise, one word per clock in and out. A load word (opcode 0) writes one
// permutation entry and returns nothing; a sample word (opcode 1) presents one Q2.14 noise
// value on the output after it passes the pipeline. The permutation table is held in six copies
// of a 256 x 8 synchronous RAM, all written together, so the two cell lookups and the four
// corner lookups of each sample each have a port of their own; a per-entry valid bit makes
// an entry that was never loaded read as its own index. The pipeline moves as a whole and
// holds only while the output word waits to be taken.
module perlin_noise_2d_top #(
    parameter int FRAC_BITS = pn2d_pkg::FRAC_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    pn2d_in_if.sink     din,
    pn2d_out_if.source  dout
);
    import pn2d_pkg::*;

    localparam int DW    = FRAC_BITS + 3;
    localparam int LW    = DW + 18;
    localparam int AW    = LW + 18;
    localparam int SH    = FRAC_BITS + 18;
    localparam int RW    = AW - SH;
    localparam int NRAM  = 6;
    localparam int ONE_I = 1 << FRAC_BITS;

    localparam logic signed [DW-1:0] ONE      = DW'(ONE_I);
    localparam logic signed [17:0]   W_ONE    = 18'sd65536;
    localparam logic signed [AW-1:0] HALF     = AW'(1) <<< (SH - 1);
    localparam logic signed [RW-1:0] NOISE_HI = RW'(32767);
    localparam logic signed [RW-1:0] NOISE_LO = -RW'(32768);

    function automatic logic signed [DW-1:0] grad_dot(
        input logic [1:0]           h,
        input logic signed [DW-1:0] dx,
        input logic signed [DW-1:0] dy
    );
        logic signed [DW-1:0] res;
        case (h)
            GRAD_PP: res = dx + dy;
            GRAD_NP: res = dy - dx;
            GRAD_NN: res = -dx - dy;
            GRAD_PN: res = dx - dy;
            default: res = dx + dy;
        endcase
        return res;
    endfunction

    logic adv;
    logic take;
    logic tbl_we;
    logic smp_in;

    assign adv       = !dout.valid || dout.ready;
    assign din.ready = adv;
    assign take      = din.valid && adv;
    assign tbl_we    = take && (din.opcode == OP_LOAD);
    assign smp_in    = take && (din.opcode == OP_SAMPLE);

    // table lookups
    perm_t rd_addr [NRAM];
    perm_t rd_data [NRAM];
    perm_t aq_reg  [NRAM];
    logic  hv_reg  [NRAM];
    perm_t entry   [NRAM];
    logic [TABLE_DEPTH-1:0] tvalid_reg;

    genvar g;
    generate
        for (g = 0; g < NRAM; g++)
        begin : g_ram
            pn2d_perm_ram u_ram (
                .clk     (clk),
                .wr_en   (tbl_we),
                .wr_addr (din.table_index),
                .wr_data (din.table_value),
                .rd_en   (adv),
                .rd_addr (rd_addr[g]),
                .rd_data (rd_data[g])
            );
            assign entry[g] = hv_reg[g] ? rd_data[g] : aq_reg[g];
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < NRAM; i++)
            begin
                aq_reg[i] <= rd_addr[i];
                hv_reg[i] <= tvalid_reg[rd_addr[i]];
            end
        end
    end

    // stage 0: cell and fraction from the input word
    perm_t cx_next;
    perm_t cy_next;
    logic [FRAC_BITS-1:0] fx_next;
    logic [FRAC_BITS-1:0] fy_next;

    assign cx_next = din.x_coord[FRAC_BITS +: 8];
    assign cy_next = din.y_coord[FRAC_BITS +: 8];
    assign fx_next = din.x_coord[FRAC_BITS-1:0];
    assign fy_next = din.y_coord[FRAC_BITS-1:0];

    // stage 1 registers
    perm_t cy_reg;
    perm_t cy1_reg;
    logic [FRAC_BITS-1:0] fx1_reg;
    logic [FRAC_BITS-1:0] fy1_reg;

    // stage 2 registers
    logic [FRAC_BITS-1:0] fx2_reg;
    logic [FRAC_BITS-1:0] fy2_reg;

    // cell and corner hash addresses
    always_comb
    begin
        rd_addr[0] = cx_next;
        rd_addr[1] = cx_next + 8'd1;
        rd_addr[2] = entry[0] + cy_reg;
        rd_addr[3] = entry[0] + cy1_reg;
        rd_addr[4] = entry[1] + cy_reg;
        rd_addr[5] = entry[1] + cy1_reg;
    end

    // stage 2 to 3: gradient dot products
    logic signed [DW-1:0] dx0_next;
    logic signed [DW-1:0] dy0_next;
    logic signed [DW-1:0] dx1_next;
    logic signed [DW-1:0] dy1_next;
    logic signed [DW-1:0] bl_reg;
    logic signed [DW-1:0] tl_reg;
    logic signed [DW-1:0] br_reg;
    logic signed [DW-1:0] tr_reg;

    assign dx0_next = $signed({3'b000, fx2_reg});
    assign dy0_next = $signed({3'b000, fy2_reg});
    assign dx1_next = dx0_next - ONE;
    assign dy1_next = dy0_next - ONE;

    // fade weights, ready at stage 3
    weight_t u_w;
    weight_t v_w;

    pn2d_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_x (
        .clk    (clk),
        .en     (adv),
        .frac   (fx_next),
        .weight (u_w)
    );

    pn2d_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_y (
        .clk    (clk),
        .en     (adv),
        .frac   (fy_next),
        .weight (v_w)
    );

    // stage 3 to 4: blend along y
    logic signed [17:0]   wv_next;
    logic signed [17:0]   iv_next;
    logic signed [LW-1:0] p_bl_next;
    logic signed [LW-1:0] p_tl_next;
    logic signed [LW-1:0] p_br_next;
    logic signed [LW-1:0] p_tr_next;
    logic signed [LW-1:0] left_reg;
    logic signed [LW-1:0] right_reg;
    weight_t u4_reg;

    always_comb
    begin
        wv_next   = $signed({2'b00, v_w});
        iv_next   = W_ONE - wv_next;
        p_bl_next = LW'(bl_reg) * LW'(iv_next);
        p_tl_next = LW'(tl_reg) * LW'(wv_next);
        p_br_next = LW'(br_reg) * LW'(iv_next);
        p_tr_next = LW'(tr_reg) * LW'(wv_next);
    end

    // stage 4 to 5: blend along x
    logic signed [17:0]   wu_next;
    logic signed [17:0]   iu_next;
    logic signed [AW-1:0] p_l_next;
    logic signed [AW-1:0] p_r_next;
    logic signed [AW-1:0] acc_reg;

    always_comb
    begin
        wu_next  = $signed({2'b00, u4_reg});
        iu_next  = W_ONE - wu_next;
        p_l_next = AW'(left_reg) * AW'(iu_next);
        p_r_next = AW'(right_reg) * AW'(wu_next);
    end

    // stage 5 to output: round half up, then clamp
    logic signed [AW-1:0] rnd_next;
    logic signed [RW-1:0] r_next;
    noise_t               noise_next;
    noise_t               noise_reg;

    always_comb
    begin
        rnd_next = (acc_reg + HALF) >>> SH;
        r_next   = rnd_next[RW-1:0];
        if (r_next > NOISE_HI)
        begin
            noise_next = 16'sh7FFF;
        end
        else if (r_next < NOISE_LO)
        begin
            noise_next = 16'sh8000;
        end
        else
        begin
            noise_next = r_next[15:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cy_reg    <= cy_next;
            cy1_reg   <= cy_next + 8'd1;
            fx1_reg   <= fx_next;
            fy1_reg   <= fy_next;
            fx2_reg   <= fx1_reg;
            fy2_reg   <= fy1_reg;
            bl_reg    <= grad_dot(entry[2][1:0], dx0_next, dy0_next);
            tl_reg    <= grad_dot(entry[3][1:0], dx0_next, dy1_next);
            br_reg    <= grad_dot(entry[4][1:0], dx1_next, dy0_next);
            tr_reg    <= grad_dot(entry[5][1:0], dx1_next, dy1_next);
            left_reg  <= p_bl_next + p_tl_next;
            right_reg <= p_br_next + p_tr_next;
            u4_reg    <= u_w;
            acc_reg   <= p_l_next + p_r_next;
            noise_reg <= noise_next;
        end
    end

    // control: stage valids and table valid bits
    logic v1_reg;
    logic v2_reg;
    logic v3_reg;
    logic v4_reg;
    logic v5_reg;
    logic ov_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            v3_reg     <= 1'b0;
            v4_reg     <= 1'b0;
            v5_reg     <= 1'b0;
            ov_reg     <= 1'b0;
            tvalid_reg <= '0;
        end
        else
        begin
            if (adv)
            begin
                v1_reg <= smp_in;
                v2_reg <= v1_reg;
                v3_reg <= v2_reg;
                v4_reg <= v3_reg;
                v5_reg <= v4_reg;
                ov_reg <= v5_reg;
            end
            if (tbl_we)
            begin
                tvalid_reg[din.table_index] <= 1'b1;
            end
        end
    end

    assign dout.valid       = ov_reg;
    assign dout.noise_value = noise_reg;
endmodule

// ===== design/pn2d_perm_ram.sv =====
module pn2d_perm_ram (
    input  logic              clk,
    input  logic              wr_en,
    input  pn2d_pkg::perm_t   wr_addr,
    input  pn2d_pkg::perm_t   wr_data,
    input  logic              rd_en,
    input  pn2d_pkg::perm_t   rd_addr,
    output pn2d_pkg::perm_t   rd_data
);
    import pn2d_pkg::*;

    perm_t mem [TABLE_DEPTH];
    perm_t rd_data_reg;

    // read returns the old entry when the same address is written in the same cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

// ===== design/pn2d_fade.sv =====
module pn2d_fade #(
    parameter int FRAC_BITS = pn2d_pkg::FRAC_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  en,
    input  logic [FRAC_BITS-1:0]  frac,
    output pn2d_pkg::weight_t     weight
);
    import pn2d_pkg::*;

    // 6t^5 - 15t^4 + 10t^3 evaluated as t^3 * (10 - 15t + 6t^2), Q0.16
    logic [15:0] t_next;
    logic [31:0] tt_next;
    logic [15:0] t_reg;
    logic [15:0] t2_reg;

    logic [31:0] t3_wide_next;
    logic [20:0] p_wide_next;
    logic [15:0] t3_reg;
    logic [19:0] p_reg;

    logic [35:0] w_prod_next;
    logic [19:0] w_wide_next;
    logic [15:0] w_next;
    logic [15:0] w_reg;

    always_comb
    begin
        t_next       = 16'(frac) << (16 - FRAC_BITS);
        tt_next      = 32'(t_next) * 32'(t_next);
        t3_wide_next = 32'(t2_reg) * 32'(t_reg);
        p_wide_next  = 21'd655360 + 21'(t2_reg) * 21'd6 - 21'(t_reg) * 21'd15;
        w_prod_next  = 36'(t3_reg) * 36'(p_reg);
        w_wide_next  = w_prod_next[35:16];
        w_next       = (w_wide_next > 20'd65535) ? 16'hFFFF : w_wide_next[15:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg  <= t_next;
            t2_reg <= tt_next[31:16];
            t3_reg <= t3_wide_next[31:16];
            p_reg  <= p_wide_next[19:0];
            w_reg  <= w_next;
        end
    end

    assign weight = w_reg;
endmodule

// ===== bench/perlin_noise_2d_checker.sv =====
`timescale 1ns / 1ps

module perlin_noise_2d_checker
    import pn2d_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    pn2d_in_if   din,
    pn2d_out_if  dout,
    output int   fail_count,
    output int   pending_words
);

    localparam longint ONE   = longint'(1) << FRAC_BITS;
    localparam longint FMASK = ONE - 1;
    localparam int     SHIFT = FRAC_BITS + 18;
    localparam int     MAX_PRINTED = 100;

    perm_t  perm_copy [TABLE_DEPTH];
    noise_t expected_noise [$];
    noise_t want;

    task automatic report_mismatch(input string what);
        if (fail_count < MAX_PRINTED)
        begin
            $display("%0t ns: %s", $time, what);
        end
        fail_count++;
    endtask

    // quintic fade 6t^5 - 15t^4 + 10t^3 in Q0.16
    function automatic longint fade_weight(input longint frac);
        longint t, t2, t3, p, w;
        t  = frac << (16 - FRAC_BITS);
        t2 = (t * t) >> 16;
        t3 = (t2 * t) >> 16;
        p  = 10 * 65536 + 6 * t2 - 15 * t;
        w  = (t3 * p) >> 16;
        if (w > 65535)
        begin
            w = 65535;
        end
        return w;
    endfunction

    function automatic longint gradient_dot(input logic [1:0] h, input longint dx,
                                            input longint dy);
        case (h)
            GRAD_PP: return dx + dy;
            GRAD_NP: return dy - dx;
            GRAD_NN: return -dx - dy;
            default: return dx - dy;
        endcase
    endfunction

    function automatic noise_t noise_at(input coord_t xc, input coord_t yc);
        longint x, y, dx0, dy0, dx1, dy1;
        longint bl, tl, br, tr, lft, rgt, acc, r, u, v;
        perm_t  cx, cy, cx1, cy1, px0, px1, hbl, htl, hbr, htr;
        x   = longint'(xc);
        y   = longint'(yc);
        // arithmetic shift floors, the cast keeps the cell modulo 256
        cx  = perm_t'(x >>> FRAC_BITS);
        cy  = perm_t'(y >>> FRAC_BITS);
        cx1 = cx + 8'd1;
        cy1 = cy + 8'd1;
        dx0 = x & FMASK;
        dy0 = y & FMASK;
        dx1 = dx0 - ONE;
        dy1 = dy0 - ONE;
        px0 = perm_copy[cx];
        px1 = perm_copy[cx1];
        hbl = perm_copy[perm_t'(px0 + cy)];
        htl = perm_copy[perm_t'(px0 + cy1)];
        hbr = perm_copy[perm_t'(px1 + cy)];
        htr = perm_copy[perm_t'(px1 + cy1)];
        bl  = gradient_dot(hbl[1:0], dx0, dy0);
        tl  = gradient_dot(htl[1:0], dx0, dy1);
        br  = gradient_dot(hbr[1:0], dx1, dy0);
        tr  = gradient_dot(htr[1:0], dx1, dy1);
        u   = fade_weight(dx0);
        v   = fade_weight(dy0);
        lft = bl * (65536 - v) + tl * v;
        rgt = br * (65536 - v) + tr * v;
        acc = lft * (65536 - u) + rgt * u;
        r   = (acc + (longint'(1) << (SHIFT - 1))) >>> SHIFT;
        if (r > 32767)
        begin
            r = 32767;
        end
        if (r < -32768)
        begin
            r = -32768;
        end
        return noise_t'(r);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                perm_copy[i] = perm_t'(i);
            end
            expected_noise.delete();
            fail_count    = 0;
            pending_words = 0;
        end
        else
        begin
            if (din.valid === 1'b1 && din.ready === 1'b1)
            begin
                if (din.opcode == OP_LOAD)
                begin
                    perm_copy[din.table_index] = din.table_value;
                end
                else
                begin
                    expected_noise.push_back(noise_at(din.x_coord, din.y_coord));
                end
            end
            if (dout.valid === 1'b1 && dout.ready === 1'b1)
            begin
                if (expected_noise.size() == 0)
                begin
                    report_mismatch($sformatf("noise word %0d with nothing expected",
                                              dout.noise_value));
                end
                else
                begin
                    want = expected_noise.pop_front();
                    if (dout.noise_value !== want)
                    begin
                        report_mismatch($sformatf("noise_value got %0d expected %0d",
                                                  dout.noise_value, want));
                    end
                end
            end
            pending_words = expected_noise.size();
        end
    end

endmodule

// ===== bench/perlin_noise_2d_top_tb.sv =====
`timescale 1ns / 1ps

module perlin_noise_2d_top_tb;
    import pn2d_pkg::*;

    localparam int FRAC_BITS    = FRAC_BITS_DEF;
    localparam int RANDOM_WORDS = 1800;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 30;

    logic clk = 1'b0;
    logic rst_n;
    bit   burst_mode = 1'b0;
    int   fail_count;
    int   pending_words;

    pn2d_in_if  in_ch ();
    pn2d_out_if out_ch ();

    perlin_noise_2d_top #(
        .FRAC_BITS(FRAC_BITS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (in_ch),
        .dout  (out_ch)
    );

    perlin_noise_2d_checker #(
        .FRAC_BITS(FRAC_BITS)
    ) checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .din           (in_ch),
        .dout          (out_ch),
        .fail_count    (fail_count),
        .pending_words (pending_words)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic coord_t rand_coord();
        logic [7:0] frac;
        case ($urandom_range(0, 3))
            0: return coord_t'($urandom_range(0, 4095)) - coord_t'(2048);
            1:
            begin
                case ($urandom_range(0, 3))
                    0:       frac = 8'h00;
                    1:       frac = 8'hFF;
                    2:       frac = 8'h80;
                    default: frac = 8'h01;
                endcase
                return {16'($urandom), frac};
            end
            default: return coord_t'($urandom);
        endcase
    endfunction

    task automatic send_word(input opcode_t op, input perm_t idx, input perm_t val,
                             input coord_t x, input coord_t y);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.opcode      <= op;
        in_ch.table_index <= idx;
        in_ch.table_value <= val;
        in_ch.x_coord     <= x;
        in_ch.y_coord     <= y;
        do @(posedge clk);
        while (!(in_ch.valid === 1'b1 && in_ch.ready === 1'b1));
    endtask

    task automatic load_entry(input perm_t idx, input perm_t val);
        send_word(OP_LOAD, idx, val, coord_t'($urandom), coord_t'($urandom));
    endtask

    task automatic sample_at(input coord_t x, input coord_t y);
        send_word(OP_SAMPLE, perm_t'($urandom), perm_t'($urandom), x, y);
    endtask

    // result side: outside burst mode, may hold ready low for a random gap before taking each word
    initial
    begin
        int gap;
        out_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            gap = burst_mode ? 0 : $urandom_range(0, 8);
            if (gap > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk);
            while (!(out_ch.valid === 1'b1 && out_ch.ready === 1'b1));
        end
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        rst_n             <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.opcode      <= OP_LOAD;
        in_ch.table_index <= '0;
        in_ch.table_value <= '0;
        in_ch.x_coord     <= '0;
        in_ch.y_coord     <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // corners of the coordinate range and fraction edge cases on the identity table
        sample_at(24'sh000000, 24'sh000000);
        sample_at(24'sh7FFFFF, 24'sh7FFFFF);
        sample_at(coord_t'(24'h800000), coord_t'(24'h800000));
        sample_at(coord_t'(24'h800000), 24'sh7FFFFF);
        sample_at(24'sh7FFFFF, coord_t'(24'h800000));
        sample_at(coord_t'(24'hFFFFFF), coord_t'(24'hFFFFFF));
        sample_at(24'sh000080, 24'sh000080);
        sample_at(24'sh0000FF, 24'sh000001);

        // all four corners point at the cell center: +1.0
        load_entry(8'd0, 8'd10);
        load_entry(8'd1, 8'd20);
        load_entry(8'd10, {6'd0, GRAD_PP});
        load_entry(8'd11, {6'd0, GRAD_PN});
        load_entry(8'd20, {6'd0, GRAD_NP});
        load_entry(8'd21, {6'd0, GRAD_NN});
        sample_at(24'sh000080, 24'sh000080);

        // all four corners point away: -1.0
        load_entry(8'd10, {6'd0, GRAD_NN});
        load_entry(8'd11, {6'd0, GRAD_NP});
        load_entry(8'd20, {6'd0, GRAD_PN});
        load_entry(8'd21, {6'd0, GRAD_PP});
        sample_at(24'sh000080, 24'sh000080);

        // cell 255 so the corner and hash indexes wrap
        load_entry(8'd255, 8'd255);
        sample_at(coord_t'(24'hFFFF80), coord_t'(24'hFFFF80));
        sample_at(24'sh7FFF80, 24'sh00FF80);

        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n % 150 == 0)
            begin
                burst_mode = ($urandom_range(0, 3) == 0);
            end
            if ($urandom_range(0, 4) == 0)
            begin
                load_entry(perm_t'($urandom), perm_t'($urandom));
            end
            else
            begin
                sample_at(rand_coord(), rand_coord());
            end
        end
        in_ch.valid <= 1'b0;

        do @(negedge clk);
        while (pending_words != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/pn2d_pkg.sv
design/pn2d_in_if.sv
design/pn2d_out_if.sv
design/pn2d_perm_ram.sv
design/pn2d_fade.sv
design/perlin_noise_2d_top.sv
bench/perlin_noise_2d_checker.sv
bench/perlin_noise_2d_top_tb.sv
